### hw/rtl/tdq_pkg.sv
// Shared types and constants for the timer deadline queue.
// No dependencies; used by every module of the block.
`default_nettype none

package tdq_pkg;

    localparam int ID_W       = 4;
    localparam int TIME_W     = 64;
    localparam int ACTION_W   = 2;
    localparam int MAX_FIRE   = 16;
    localparam int FIRE_CNT_W = 4;

    localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CANCEL   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DELETE,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELETE,
        ST_INSERT,
        ST_REPORT,
        ST_SCAN,
        ST_POP
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   key;
        logic [TIME_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/timer_deadline_queue.sv
// Timer deadline queue top level: sequencer plus a sorted chain of timer cells.
// Depends on tdq_pkg and tdq_cell.
`default_nettype none

// Armed timers sit in a chain of NUM_TIMERS cells kept sorted by deadline,
// equal deadlines in arming order, so the earliest timer is always in the
// first cell. start is taken while busy is low. Each step walks the chain
// one whole-chain operation per cycle: a schedule removes any old entry,
// inserts and reports, a cancel removes and reports, a dispatch that
// expires nothing scans and reports, and a dispatch that expires timers
// scans and then pops them, giving one fired id per cycle as the head
// cell is popped. Every result is shown for one cycle under result_strobe
// and cannot be held off; the results of one step come in consecutive
// cycles, the final one marked by last. At most 16 timers fire per dispatch.
module timer_deadline_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tdq_pkg::ACTION_W-1:0]  action,
    input  wire logic [tdq_pkg::ID_W-1:0]      timer_id,
    input  wire logic [tdq_pkg::TIME_W-1:0]    time_value,
    output logic                               result_strobe,
    output logic                               fired_valid,
    output logic [tdq_pkg::ID_W-1:0]           fired_id,
    output logic                               was_armed,
    output logic [tdq_pkg::TIME_W-1:0]         next_deadline,
    output logic                               last
);

    tdq_pkg::state_t                    state_reg;
    tdq_pkg::state_t                    state_next;
    logic [tdq_pkg::ACTION_W-1:0]       action_reg;
    logic [tdq_pkg::ACTION_W-1:0]       action_next;
    logic [tdq_pkg::ID_W-1:0]           key_reg;
    logic [tdq_pkg::ID_W-1:0]           key_next;
    logic [tdq_pkg::TIME_W-1:0]         value_reg;
    logic [tdq_pkg::TIME_W-1:0]         value_next;
    logic                               was_reg;
    logic                               was_next;
    logic [tdq_pkg::FIRE_CNT_W-1:0]     pops_reg;
    logic [tdq_pkg::FIRE_CNT_W-1:0]     pops_next;
    logic [tdq_pkg::TIME_W-1:0]         disp_next_reg;
    logic [tdq_pkg::TIME_W-1:0]         disp_next_next;

    logic                               strobe_reg;
    logic                               strobe_next;
    logic                               fired_valid_reg;
    logic                               fired_valid_next;
    logic [tdq_pkg::ID_W-1:0]           fired_id_reg;
    logic [tdq_pkg::ID_W-1:0]           fired_id_next;
    logic                               was_armed_reg;
    logic                               was_armed_next;
    logic [tdq_pkg::TIME_W-1:0]         next_deadline_reg;
    logic [tdq_pkg::TIME_W-1:0]         next_deadline_next;
    logic                               last_reg;
    logic                               last_next;

    tdq_pkg::cmd_t                      cmd;
    tdq_pkg::entry_t                    cell_entry [NUM_TIMERS+1];
    logic                               cell_le    [NUM_TIMERS+1];
    logic                               cell_match [NUM_TIMERS+1];
    logic [tdq_pkg::TIME_W-1:0]         head_deadline;
    logic [tdq_pkg::TIME_W-1:0]         boundary_deadline;
    logic                               pop_last;
    logic                               id_ok;

    assign busy          = (state_reg != tdq_pkg::ST_IDLE);
    assign result_strobe = strobe_reg;
    assign fired_valid   = fired_valid_reg;
    assign fired_id      = fired_id_reg;
    assign was_armed     = was_armed_reg;
    assign next_deadline = next_deadline_reg;
    assign last          = last_reg;

    assign cell_entry[NUM_TIMERS] = '0;
    assign cell_le[NUM_TIMERS]    = 1'b0;
    assign cell_match[0]          = 1'b0;

    always_comb
    begin
        cmd.key   = key_reg;
        cmd.value = value_reg;
        unique case (state_reg)
            tdq_pkg::ST_DELETE: cmd.op = tdq_pkg::OP_DELETE;
            tdq_pkg::ST_INSERT: cmd.op = tdq_pkg::OP_INSERT;
            tdq_pkg::ST_POP:    cmd.op = tdq_pkg::OP_POP;
            default:            cmd.op = tdq_pkg::OP_HOLD;
        endcase
    end

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        tdq_pkg::entry_t left_entry;
        logic            left_le;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_le    = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_le    = cell_le[i-1];
        end

        tdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (cell_entry[i+1]),
            .match_in    (cell_match[i]),
            .match_out   (cell_match[i+1]),
            .entry       (cell_entry[i]),
            .le          (cell_le[i])
        );
    end

    assign head_deadline = cell_entry[0].valid ? cell_entry[0].deadline : '1;
    assign id_ok         = (32'(timer_id) < NUM_TIMERS);
    assign pop_last      = (pops_reg == tdq_pkg::FIRE_CNT_W'(tdq_pkg::MAX_FIRE - 1))
                           || !cell_le[1];

    // New head after a dispatch: first cell past the expired prefix, capped
    always_comb
    begin
        boundary_deadline = '1;
        for (int i = 1; i < NUM_TIMERS; i++)
        begin
            if (cell_le[i-1] && ((i - 1) < tdq_pkg::MAX_FIRE)
                && !(cell_le[i] && (i < tdq_pkg::MAX_FIRE))
                && cell_entry[i].valid)
            begin
                boundary_deadline = cell_entry[i].deadline;
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        action_next        = action_reg;
        key_next           = key_reg;
        value_next         = value_reg;
        was_next           = was_reg;
        pops_next          = pops_reg;
        disp_next_next     = disp_next_reg;
        strobe_next        = 1'b0;
        fired_valid_next   = fired_valid_reg;
        fired_id_next      = fired_id_reg;
        was_armed_next     = was_armed_reg;
        next_deadline_next = next_deadline_reg;
        last_next          = last_reg;

        unique case (state_reg)
            tdq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    key_next    = timer_id;
                    value_next  = time_value;
                    was_next    = 1'b0;
                    if (action == tdq_pkg::ACT_DISPATCH)
                    begin
                        state_next = tdq_pkg::ST_SCAN;
                    end
                    else if ((action == tdq_pkg::ACT_SCHEDULE
                              || action == tdq_pkg::ACT_CANCEL) && id_ok)
                    begin
                        state_next = tdq_pkg::ST_DELETE;
                    end
                    else
                    begin
                        state_next = tdq_pkg::ST_REPORT;
                    end
                end
            end
            tdq_pkg::ST_DELETE:
            begin
                was_next = cell_match[NUM_TIMERS];
                if (action_reg == tdq_pkg::ACT_SCHEDULE)
                begin
                    state_next = tdq_pkg::ST_INSERT;
                end
                else
                begin
                    state_next = tdq_pkg::ST_REPORT;
                end
            end
            tdq_pkg::ST_INSERT:
            begin
                state_next = tdq_pkg::ST_REPORT;
            end
            tdq_pkg::ST_REPORT:
            begin
                strobe_next        = 1'b1;
                fired_valid_next   = 1'b0;
                fired_id_next      = '0;
                was_armed_next     = was_reg;
                next_deadline_next = head_deadline;
                last_next          = 1'b1;
                state_next         = tdq_pkg::ST_IDLE;
            end
            tdq_pkg::ST_SCAN:
            begin
                if (!cell_le[0])
                begin
                    strobe_next        = 1'b1;
                    fired_valid_next   = 1'b0;
                    fired_id_next      = '0;
                    was_armed_next     = 1'b0;
                    next_deadline_next = head_deadline;
                    last_next          = 1'b1;
                    state_next         = tdq_pkg::ST_IDLE;
                end
                else
                begin
                    disp_next_next = boundary_deadline;
                    pops_next      = '0;
                    state_next     = tdq_pkg::ST_POP;
                end
            end
            tdq_pkg::ST_POP:
            begin
                strobe_next        = 1'b1;
                fired_valid_next   = 1'b1;
                fired_id_next      = cell_entry[0].id;
                was_armed_next     = 1'b0;
                next_deadline_next = disp_next_reg;
                last_next          = pop_last;
                pops_next          = pops_reg + 1'b1;
                if (pop_last)
                begin
                    state_next = tdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tdq_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
            pops_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            pops_reg   <= pops_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg        <= action_next;
        key_reg           <= key_next;
        value_reg         <= value_next;
        was_reg           <= was_next;
        disp_next_reg     <= disp_next_next;
        fired_valid_reg   <= fired_valid_next;
        fired_id_reg      <= fired_id_next;
        was_armed_reg     <= was_armed_next;
        next_deadline_reg <= next_deadline_next;
        last_reg          <= last_next;
    end

endmodule

`default_nettype wire

### hw/rtl/tdq_cell.sv
// One cell of the sorted timer chain: holds one armed timer and its deadline.
// Depends on tdq_pkg for the entry and command types.
`default_nettype none

module tdq_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tdq_pkg::cmd_t      cmd,
    input  wire tdq_pkg::entry_t    left_entry,
    input  wire logic          left_le,
    input  wire tdq_pkg::entry_t    right_entry,
    input  wire logic          match_in,
    output logic               match_out,
    output tdq_pkg::entry_t    entry,
    output logic               le
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [tdq_pkg::ID_W-1:0]      id_reg;
    logic [tdq_pkg::ID_W-1:0]      id_next;
    logic [tdq_pkg::TIME_W-1:0]    deadline_reg;
    logic [tdq_pkg::TIME_W-1:0]    deadline_next;
    logic                          is_match;

    assign entry.valid    = valid_reg;
    assign entry.id       = id_reg;
    assign entry.deadline = deadline_reg;

    assign le        = valid_reg && (deadline_reg <= cmd.value);
    assign is_match  = valid_reg && (id_reg == cmd.key);
    assign match_out = match_in | is_match;

    always_comb
    begin
        valid_next    = valid_reg;
        id_next       = id_reg;
        deadline_next = deadline_reg;
        unique case (cmd.op)
            tdq_pkg::OP_DELETE:
            begin
                if (match_out)
                begin
                    valid_next    = right_entry.valid;
                    id_next       = right_entry.id;
                    deadline_next = right_entry.deadline;
                end
            end
            tdq_pkg::OP_INSERT:
            begin
                if (!left_le)
                begin
                    valid_next    = left_entry.valid;
                    id_next       = left_entry.id;
                    deadline_next = left_entry.deadline;
                end
                else if (!le)
                begin
                    valid_next    = 1'b1;
                    id_next       = cmd.key;
                    deadline_next = cmd.value;
                end
            end
            tdq_pkg::OP_POP:
            begin
                valid_next    = right_entry.valid;
                id_next       = right_entry.id;
                deadline_next = right_entry.deadline;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        deadline_reg <= deadline_next;
    end

endmodule

`default_nettype wire

### hw/rtl/tdq_checker.sv
// Port-level checks for the timer deadline queue, bound to the top level.
// Depends on tdq_pkg for field widths.
`default_nettype none

module tdq_port_checks (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          result_strobe,
    input wire logic                          fired_valid,
    input wire logic [tdq_pkg::ID_W-1:0]      fired_id,
    input wire logic                          was_armed,
    input wire logic                          last
);

    // A transfer always leaves the block busy in the following cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low straight after a transfer");

    a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |=> result_strobe && fired_valid)
        else $error("dispatch burst broken before its last result");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !result_strobe)
        else $error("result straight after the final result of a step");

    a_ids_differ: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && fired_valid && !last |=> fired_id != $past(fired_id))
        else $error("same timer fired twice in one dispatch");

    a_armed_not_fired: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && was_armed |-> !fired_valid)
        else $error("fired result reports an armed timer");

endmodule

bind timer_deadline_queue tdq_port_checks u_port_checks (.*);

`default_nettype wire
